/* hdl/ajsk_pkg.sv */
// Shared types, register indexes, the Q1.14 sine table and default
// sizes for the arm joint stepper and kinematics core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ajsk_pkg;

  localparam int TrigBitsDef  = 16;
  localparam int CoordBitsDef = 24;
  localparam int FieldBits    = 24;
  localparam int MulABits     = 18;   // widest multiplicand: lengths and link projections

  localparam logic [2:0] REG_BASE_X    = 3'd0;
  localparam logic [2:0] REG_BASE_Y    = 3'd1;
  localparam logic [2:0] REG_BASE_Z    = 3'd2;
  localparam logic [2:0] REG_BASE_TALL = 3'd3;
  localparam logic [2:0] REG_LOWER_LEN = 3'd4;
  localparam logic [2:0] REG_UPPER_LEN = 3'd5;

  localparam logic [1:0] MODE_BASE  = 2'd0;
  localparam logic [1:0] MODE_LOWER = 2'd1;
  localparam logic [1:0] MODE_UPPER = 2'd2;
  localparam logic [1:0] MODE_HOME  = 2'd3;

  typedef struct packed {
    logic start;
    logic accum;   // add onto the running sum instead of clearing it
    logic neg;     // subtract this product
  } mul_ctl_t;

  function automatic logic [14:0] sin_q14(input logic [6:0] idx);
    logic [14:0] v;
    unique case (idx)
      7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
      7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
      7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
      7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
      7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
      7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
      7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
      7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
      7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
      7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
      7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
      7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
      7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
      7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
      7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
      7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
      7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
      7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
      7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
      7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
      7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
      default: v = 15'd16384;  // 90 and above
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/ajsk_if.sv */
// Valid/ready channel interfaces for joint commands and kinematics results.
// Depends on nothing but the field widths written here.
`timescale 1ns / 1ps
`default_nettype none
interface ajsk_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [3:0] direction;
  modport source (output valid, mode, direction, input ready);
  modport sink   (input valid, mode, direction, output ready);
endinterface

interface ajsk_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         base_deg;
  logic signed [6:0]  lower_deg;
  logic signed [7:0]  upper_deg;
  logic signed [23:0] elbow_x;
  logic signed [23:0] elbow_y;
  logic signed [23:0] elbow_z;
  logic signed [23:0] tip_x;
  logic signed [23:0] tip_y;
  logic signed [23:0] tip_z;
  modport source (output valid, base_deg, lower_deg, upper_deg, elbow_x, elbow_y,
                  elbow_z, tip_x, tip_y, tip_z, input ready);
  modport sink   (input valid, base_deg, lower_deg, upper_deg, elbow_x, elbow_y,
                  elbow_z, tip_x, tip_y, tip_z, output ready);
endinterface
`default_nettype wire

/* hdl/arm_joint_step_and_kinematics_core.sv */
// Joint stepper and three-link forward kinematics, top level.
// A command passes the joint step, the trig lookups, twelve products through one
// bit-serial multiplier, the coordinate sums and the output register.
// One command at a time; a new command is taken the cycle after the previous
// result is loaded into the output register.
// Reset (rst_n, sync): angles 45/0/-35, base 0,0,0, height and links 1.0.
`timescale 1ns / 1ps
`default_nettype none
module arm_joint_step_and_kinematics_core #(
  parameter int TRIG_BITS  = ajsk_pkg::TrigBitsDef,
  parameter int COORD_BITS = ajsk_pkg::CoordBitsDef
) (
  input  wire              clk,
  input  wire              rst_n,
  ajsk_in_if.sink          in_ch,
  ajsk_out_if.source       out_ch,
  input  wire              cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata
);
  localparam int AW   = ajsk_pkg::MulABits;
  localparam int TB   = TRIG_BITS;
  localparam int PW   = AW + TB;
  localparam int F    = TB - 2;               // trig fraction bits
  localparam int SHL  = (F >= 14) ? F - 14 : 0;
  localparam int SHR  = (F < 14) ? 14 - F : 0;
  localparam int TW   = TB + 16;
  localparam int SW   = (COORD_BITS > 28) ? COORD_BITS : 28;  // coordinate sum width
  localparam int FB   = ajsk_pkg::FieldBits;
  localparam logic signed [SW-1:0] C_HI = SW'((longint'(1) << (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] C_LO = -C_HI - SW'(1);

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TRIG   = 6'b000010,
    S_MSTART = 6'b000100,
    S_MWAIT  = 6'b001000,
    S_SUM    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Config registers
  logic signed [23:0] base_x_r, base_y_r, base_z_r;
  logic [15:0]        base_tall_r, lower_len_r, upper_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r    <= '0;
      base_y_r    <= '0;
      base_z_r    <= '0;
      base_tall_r <= 16'd256;
      lower_len_r <= 16'd256;
      upper_len_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ajsk_pkg::REG_BASE_X:    base_x_r    <= cfg_wdata;
        ajsk_pkg::REG_BASE_Y:    base_y_r    <= cfg_wdata;
        ajsk_pkg::REG_BASE_Z:    base_z_r    <= cfg_wdata;
        ajsk_pkg::REG_BASE_TALL: base_tall_r <= cfg_wdata[15:0];
        ajsk_pkg::REG_LOWER_LEN: lower_len_r <= cfg_wdata[15:0];
        ajsk_pkg::REG_UPPER_LEN: upper_len_r <= cfg_wdata[15:0];
        default: ;  // unused indexes dropped
      endcase
    end
  end

  // Joint angles: step and clamp on the accepting edge
  logic [6:0]        base_pos_r;
  logic signed [6:0] lower_pos_r;
  logic signed [7:0] upper_pos_r;
  logic signed [8:0] base_try, upper_try;
  logic signed [7:0] lower_try;
  logic              in_xfer;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign base_try    = $signed({2'b00, base_pos_r}) + (9'(in_ch.direction) <<< 1);
  assign lower_try   = 8'(lower_pos_r) + 8'(in_ch.direction);
  assign upper_try   = 9'(upper_pos_r) + 9'(in_ch.direction);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_pos_r  <= 7'd45;
      lower_pos_r <= 7'sd0;
      upper_pos_r <= -8'sd35;
    end else if (in_xfer) begin
      unique case (in_ch.mode)
        ajsk_pkg::MODE_BASE:
          base_pos_r <= (base_try < 0) ? 7'd0 : (base_try > 90) ? 7'd90 : base_try[6:0];
        ajsk_pkg::MODE_LOWER:
          lower_pos_r <= (lower_try < -20) ? -7'sd20 :
                         (lower_try > 45) ? 7'sd45 : lower_try[6:0];
        ajsk_pkg::MODE_UPPER:
          upper_pos_r <= (upper_try < -90) ? -8'sd90 :
                         (upper_try > 80) ? 8'sd80 : upper_try[7:0];
        ajsk_pkg::MODE_HOME: begin
          base_pos_r  <= 7'd45;
          lower_pos_r <= 7'sd0;
          upper_pos_r <= -8'sd35;
        end
      endcase
    end
  end

  // Trig lookups: table entry rescaled to F fraction bits
  function automatic logic signed [TB-1:0] scale(input logic [14:0] t);
    logic [TW-1:0] w;
    w = TW'(t) << SHL;
    if (SHR > 0) w = (w + (TW'(1) << (SHR - 1))) >> SHR;
    return TB'(w);
  endfunction

  function automatic logic [6:0] mag(input logic signed [8:0] deg);
    logic [8:0] m;
    m = (deg < 0) ? 9'(-deg) : 9'(deg);
    return (m > 9'd90) ? 7'd90 : m[6:0];
  endfunction

  logic signed [8:0]    d_deg, a_deg, p_deg;
  logic [6:0]           d_m, a_m, p_m;
  logic signed [TB-1:0] sd_v, sa_v, sp_v;
  logic signed [TB-1:0] sd_r, cd_r, sa_r, ca_r, sp_r, cp_r;

  assign d_deg = $signed({2'b00, base_pos_r}) - 9'sd45;
  assign a_deg = 9'(lower_pos_r);
  assign p_deg = -9'(upper_pos_r);
  assign d_m   = mag(d_deg);
  assign a_m   = mag(a_deg);
  assign p_m   = mag(p_deg);
  assign sd_v  = scale(ajsk_pkg::sin_q14(d_m));
  assign sa_v  = scale(ajsk_pkg::sin_q14(a_m));
  assign sp_v  = scale(ajsk_pkg::sin_q14(p_m));

  always_ff @(posedge clk) begin
    if (state_r == S_TRIG) begin
      sd_r <= d_deg[8] ? -sd_v : sd_v;
      sa_r <= a_deg[8] ? -sa_v : sa_v;
      sp_r <= p_deg[8] ? -sp_v : sp_v;
      cd_r <= scale(ajsk_pkg::sin_q14(7'd90 - d_m));
      ca_r <= scale(ajsk_pkg::sin_q14(7'd90 - a_m));
      cp_r <= scale(ajsk_pkg::sin_q14(7'd90 - p_m));
    end
  end

  // Product schedule: twelve passes through the serial multiplier.
  // px and py are two-term sums; py's second term is subtracted.
  localparam logic [3:0] OP_LAST = 4'd11;
  logic [3:0]            op_r;
  logic signed [AW-1:0]  lx_r, ly_r, ux_r, uy_r, px_r, py_r;
  logic signed [AW-1:0]  rx_r, rz_r, tx_r, tz_r;
  logic signed [AW-1:0]  mul_a;
  logic signed [TB-1:0]  mul_b;
  ajsk_pkg::mul_ctl_t    mul_ctl;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_acc;
  logic                  acc_accum, acc_neg;

  always_comb begin
    acc_accum = 1'b0;
    acc_neg   = 1'b0;
    unique case (op_r)
      4'd0:    begin mul_a = AW'($signed({1'b0, lower_len_r})); mul_b = sa_r; end
      4'd1:    begin mul_a = AW'($signed({1'b0, lower_len_r})); mul_b = ca_r; end
      4'd2:    begin mul_a = AW'($signed({1'b0, upper_len_r})); mul_b = cp_r; end
      4'd3:    begin mul_a = AW'($signed({1'b0, upper_len_r})); mul_b = sp_r; end
      4'd4:    begin mul_a = lx_r; mul_b = cd_r; end
      4'd5:    begin mul_a = lx_r; mul_b = sd_r; end
      4'd6:    begin mul_a = ux_r; mul_b = ca_r; end
      4'd7:    begin mul_a = uy_r; mul_b = sa_r; acc_accum = 1'b1; end
      4'd8:    begin mul_a = uy_r; mul_b = ca_r; end
      4'd9:    begin mul_a = ux_r; mul_b = sa_r; acc_accum = 1'b1; acc_neg = 1'b1; end
      4'd10:   begin mul_a = px_r; mul_b = cd_r; end
      default: begin mul_a = px_r; mul_b = sd_r; end
    endcase
    mul_ctl.start = (state_r == S_MSTART);
    mul_ctl.accum = acc_accum;
    mul_ctl.neg   = acc_neg;
  end

  ajsk_smul #(.AW(AW), .TB(TB)) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .acc   (mul_acc)
  );

  // Round to nearest, ties away from zero, dropping F fraction bits
  logic [PW-1:0]        acc_mag, acc_rnd;
  logic signed [AW-1:0] rnd_q;
  assign acc_mag = (mul_acc < 0) ? PW'(-mul_acc) : PW'(mul_acc);
  assign acc_rnd = (acc_mag + (PW'(1) << (F - 1))) >> F;
  assign rnd_q   = (mul_acc < 0) ? -AW'(acc_rnd) : AW'(acc_rnd);

  always_ff @(posedge clk) begin
    if (state_r == S_MWAIT && mul_done) begin
      unique case (op_r)
        4'd0:  lx_r <= rnd_q;
        4'd1:  ly_r <= rnd_q;
        4'd2:  ux_r <= rnd_q;
        4'd3:  uy_r <= rnd_q;
        4'd4:  rx_r <= rnd_q;
        4'd5:  rz_r <= rnd_q;
        4'd7:  px_r <= rnd_q;
        4'd9:  py_r <= rnd_q;
        4'd10: tx_r <= rnd_q;
        4'd11: tz_r <= rnd_q;
        default: ;  // first term of a two-term sum
      endcase
    end
  end

  // Coordinate sums
  logic signed [SW-1:0] ex_r, ey_r, ez_r, tx_s, ty_s, tz_s;

  always_ff @(posedge clk) begin
    if (state_r == S_SUM) begin
      ex_r <= SW'(base_x_r) + SW'(rx_r);
      ey_r <= SW'(base_y_r) + SW'($signed({1'b0, base_tall_r[15:1]})) + SW'(ly_r);
      ez_r <= SW'(base_z_r) + SW'(rz_r);
    end
  end

  assign tx_s = ex_r + SW'(tx_r);
  assign ty_s = ey_r + SW'(py_r);
  assign tz_s = ez_r + SW'(tz_r);

  function automatic logic signed [FB-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > C_HI) ? C_HI : (v < C_LO) ? C_LO : v;
    return c[FB-1:0];
  endfunction

  // Output register
  logic out_valid_r;
  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r       <= 1'b1;
      out_ch.base_deg   <= base_pos_r;
      out_ch.lower_deg  <= lower_pos_r;
      out_ch.upper_deg  <= upper_pos_r;
      out_ch.elbow_x    <= sat(ex_r);
      out_ch.elbow_y    <= sat(ey_r);
      out_ch.elbow_z    <= sat(ez_r);
      out_ch.tip_x      <= sat(tx_s);
      out_ch.tip_y      <= sat(ty_s);
      out_ch.tip_z      <= sat(tz_s);
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_TRIG;
      S_TRIG:   state_nxt = S_MSTART;
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT:  if (mul_done) state_nxt = (op_r == OP_LAST) ? S_SUM : S_MSTART;
      S_SUM:    state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_TRIG) op_r <= '0;
      else if (state_r == S_MWAIT && mul_done) op_r <= op_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/ajsk_smul.sv */
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on ajsk_pkg (mul_ctl_t).
`timescale 1ns / 1ps
`default_nettype none
module ajsk_smul #(
  parameter int AW = ajsk_pkg::MulABits,
  parameter int TB = ajsk_pkg::TrigBitsDef
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire ajsk_pkg::mul_ctl_t ctl,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [TB-1:0] b,
  output logic                    done,
  output logic signed [AW+TB-1:0] acc
);
  localparam int PW = AW + TB;
  localparam int CW = $clog2(TB);

  logic                 busy_r, done_r, neg_r;
  logic [CW-1:0]        cnt_r;
  logic signed [PW-1:0] a_sh_r, acc_r, term;
  logic [TB-1:0]        b_sh_r;
  logic                 last, sub;

  assign last = (cnt_r == CW'(TB - 1));
  assign term = b_sh_r[0] ? a_sh_r : '0;
  assign sub  = last ^ neg_r;  // top bit of a two's complement multiplier weighs negative

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_sh_r <= PW'(a);
        b_sh_r <= b;
        neg_r  <= ctl.neg;
        if (!ctl.accum) acc_r <= '0;
      end else if (busy_r) begin
        acc_r  <= sub ? acc_r - term : acc_r + term;
        a_sh_r <= a_sh_r <<< 1;
        b_sh_r <= b_sh_r >> 1;
        cnt_r  <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
endmodule
`default_nettype wire

/* bench/arm_joint_step_and_kinematics_core_tb.sv */
// Self-checking bench for arm_joint_step_and_kinematics_core: drives joint
// commands and register writes, predicts angles and Q16.8 positions.
// Depends on ajsk_pkg (hdl/ajsk_pkg.sv) and the channel interfaces (hdl/ajsk_if.sv).
`timescale 1ns / 1ps
module arm_joint_step_and_kinematics_core_tb;

  localparam int TrigFrac = ajsk_pkg::TrigBitsDef - 2;
  localparam int CmdCount = 1250;
  localparam int CycleLimit = 1500000;

  typedef struct packed {
    logic [6:0]         base_deg;
    logic signed [6:0]  lower_deg;
    logic signed [7:0]  upper_deg;
    logic signed [23:0] elbow_x;
    logic signed [23:0] elbow_y;
    logic signed [23:0] elbow_z;
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    logic signed [23:0] tip_z;
  } pose_t;

  // One directed row: command plus an optional hand-typed expected pose.
  typedef struct {
    logic [1:0]        mode;
    logic signed [3:0] dir;
    bit                typed;
    pose_t             pose;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [23:0] cfg_wdata = '0;

  ajsk_in_if  cmd_ch ();
  ajsk_out_if pose_ch ();

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = ajsk_pkg::MODE_HOME;
    cmd_ch.direction = '0;
    pose_ch.ready = 1'b0;
  end

  arm_joint_step_and_kinematics_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(cmd_ch), .out_ch(pose_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block: registers and joint angles.
  longint org_x, org_y, org_z, tall, lower_len, upper_len;
  int base_ang, lower_ang, upper_ang;

  pose_t pose_q[$];
  int errors = 0;
  int poses_seen = 0;
  bit calm = 1'b0;   // no random stalls on the result side
  longint cycles = 0;

  // Private copy of the Q1.14 sine table, filled once from closed form values.
  int sin_tab[91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384};

  function automatic longint trig_entry(int idx);
    longint t;
    if (idx < 0) idx = 0;
    if (idx > 90) idx = 90;
    t = longint'(sin_tab[idx]);
    if (TrigFrac >= 14) return t <<< (TrigFrac - 14);
    return (t + (longint'(1) <<< (13 - TrigFrac))) >>> (14 - TrigFrac);
  endfunction

  function automatic longint round_q(longint p);
    longint half;
    half = longint'(1) <<< (TrigFrac - 1);
    if (p >= 0) return (p + half) >>> TrigFrac;
    return -((-p + half) >>> TrigFrac);
  endfunction

  function automatic logic [23:0] clip24(longint v);
    if (v > 64'sd8388607) v = 8388607;
    if (v < -64'sd8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic int limit(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic angle_trig(input int deg, output longint s, output longint c);
    int a;
    a = deg < 0 ? -deg : deg;
    if (a > 90) a = 90;
    s = deg < 0 ? -trig_entry(a) : trig_entry(a);
    c = trig_entry(90 - a);
  endtask

  // Advance the joints for one command and compute the resulting pose.
  task automatic step_arm(input logic [1:0] mode, input logic signed [3:0] dir,
                          output pose_t p);
    longint sd, cd, sa, ca, sp, cp, lx, ly, ex, ey, ez, ux, uy, px, py;
    case (mode)
      ajsk_pkg::MODE_BASE:  base_ang = limit(base_ang + 2 * int'(dir), 0, 90);
      ajsk_pkg::MODE_LOWER: lower_ang = limit(lower_ang + int'(dir), -20, 45);
      ajsk_pkg::MODE_UPPER: upper_ang = limit(upper_ang + int'(dir), -90, 80);
      default: begin
        base_ang = 45; lower_ang = 0; upper_ang = -35;
      end
    endcase
    angle_trig(base_ang - 45, sd, cd);
    angle_trig(lower_ang, sa, ca);
    angle_trig(-upper_ang, sp, cp);
    lx = round_q(lower_len * sa);
    ly = round_q(lower_len * ca);
    ex = org_x + round_q(lx * cd);
    ey = org_y + (tall >>> 1) + ly;
    ez = org_z + round_q(lx * sd);
    ux = round_q(upper_len * cp);
    uy = round_q(upper_len * sp);
    px = round_q(ux * ca + uy * sa);
    py = round_q(uy * ca - ux * sa);
    p.base_deg = base_ang[6:0];
    p.lower_deg = lower_ang[6:0];
    p.upper_deg = upper_ang[7:0];
    p.elbow_x = clip24(ex);
    p.elbow_y = clip24(ey);
    p.elbow_z = clip24(ez);
    p.tip_x = clip24(ex + round_q(px * cd));
    p.tip_y = clip24(ey + py);
    p.tip_z = clip24(ez + round_q(px * sd));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ajsk_pkg::REG_BASE_X:    org_x = longint'(signed'(val));
      ajsk_pkg::REG_BASE_Y:    org_y = longint'(signed'(val));
      ajsk_pkg::REG_BASE_Z:    org_z = longint'(signed'(val));
      ajsk_pkg::REG_BASE_TALL: tall = longint'(val[15:0]);
      ajsk_pkg::REG_LOWER_LEN: lower_len = longint'(val[15:0]);
      ajsk_pkg::REG_UPPER_LEN: upper_len = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  // Take valid down ahead of any wait.
  task automatic cmd_stop();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until all poses are back, then let the datapath go quiet
  // before touching the registers.
  task automatic drain();
    cmd_stop();
    while (pose_q.size() != 0) @(posedge clk);
    repeat (240) @(posedge clk);
  endtask

  task automatic load_regs(input logic [23:0] bx, by, bz, input logic [15:0] bt, ll, ul);
    drain();
    write_reg(ajsk_pkg::REG_BASE_X, bx);
    write_reg(ajsk_pkg::REG_BASE_Y, by);
    write_reg(ajsk_pkg::REG_BASE_Z, bz);
    write_reg(ajsk_pkg::REG_BASE_TALL, {8'd0, bt});
    write_reg(ajsk_pkg::REG_LOWER_LEN, {8'd0, ll});
    write_reg(ajsk_pkg::REG_UPPER_LEN, {8'd0, ul});
  endtask

  // Offer one command; sender gaps come in bursts unless gaps is off.
  // Valid stays up after the transfer so the next command can follow at once.
  task automatic send_cmd(input logic [1:0] mode, input logic signed [3:0] dir,
                          input bit gaps, input bit typed, input pose_t typed_pose);
    pose_t p;
    if (gaps && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= mode;
    cmd_ch.direction <= dir;
    do @(posedge clk); while (!cmd_ch.ready);
    step_arm(mode, dir, p);
    if (typed && p != typed_pose) begin
      $error("directed row disagrees with predictor");
      errors++;
    end
    pose_q.insert(pose_q.size(), typed ? typed_pose : p);
  endtask

  // Result side: random stall bursts, field by field compare.
  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n && pose_ch.valid && pose_ch.ready) begin
      got = '{pose_ch.base_deg, pose_ch.lower_deg, pose_ch.upper_deg,
              pose_ch.elbow_x, pose_ch.elbow_y, pose_ch.elbow_z,
              pose_ch.tip_x, pose_ch.tip_y, pose_ch.tip_z};
      if (pose_q.size() == 0) begin
        $error("pose transfer with nothing expected");
        errors++;
      end else begin
        want = pose_q.pop_front();
        poses_seen++;
        if (got.base_deg != want.base_deg) begin
          $error("base_deg exp %0d got %0d", want.base_deg, got.base_deg); errors++;
        end
        if (got.lower_deg != want.lower_deg) begin
          $error("lower_deg exp %0d got %0d", want.lower_deg, got.lower_deg); errors++;
        end
        if (got.upper_deg != want.upper_deg) begin
          $error("upper_deg exp %0d got %0d", want.upper_deg, got.upper_deg); errors++;
        end
        if (got.elbow_x != want.elbow_x) begin
          $error("elbow_x exp %0d got %0d", want.elbow_x, got.elbow_x); errors++;
        end
        if (got.elbow_y != want.elbow_y) begin
          $error("elbow_y exp %0d got %0d", want.elbow_y, got.elbow_y); errors++;
        end
        if (got.elbow_z != want.elbow_z) begin
          $error("elbow_z exp %0d got %0d", want.elbow_z, got.elbow_z); errors++;
        end
        if (got.tip_x != want.tip_x) begin
          $error("tip_x exp %0d got %0d", want.tip_x, got.tip_x); errors++;
        end
        if (got.tip_y != want.tip_y) begin
          $error("tip_y exp %0d got %0d", want.tip_y, got.tip_y); errors++;
        end
        if (got.tip_z != want.tip_z) begin
          $error("tip_z exp %0d got %0d", want.tip_z, got.tip_z); errors++;
        end
      end
    end
  end

  // Ready stalls arrive as bursts; stretches of steady ready between them.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      pose_ch.ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pose_ch.ready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12);
      pose_ch.ready <= 1'b0;
    end else begin
      pose_ch.ready <= 1'b1;
    end
  end

  // Watchdog: worst case ~1250 commands * (latency + stalls) is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("arm_joint_step_and_kinematics_core_tb NOT OK");
      $finish;
    end
  end

  // Directed rows: home pose, limit clamps, every mode, extreme steps.
  // Home pose at reset settings: lower link straight up, upper bent 35 deg.
  cmd_row_t dir_rows[] = '{
    '{ajsk_pkg::MODE_HOME,  4'sd5,  1'b1,
      '{7'd45, 7'sd0, -8'sd35, 24'sd0, 24'sd384, 24'sd0,
        24'sd210, 24'sd531, 24'sd0}},
    '{ajsk_pkg::MODE_BASE,  4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE,  4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE,  4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE,  4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE, -4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE, -4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE, -4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE, -4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE, -4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_BASE, -4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_LOWER, 4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_LOWER, 4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_LOWER, 4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_LOWER, 4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_LOWER,-4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_UPPER, 4'sd7,  1'b0, '0},
    '{ajsk_pkg::MODE_UPPER,-4'sd8,  1'b0, '0},
    '{ajsk_pkg::MODE_UPPER, 4'sd0,  1'b0, '0},
    '{ajsk_pkg::MODE_HOME, -4'sd8,  1'b0, '0}
  };

  initial begin
    int n;
    logic [1:0] m;
    logic signed [3:0] d;
    org_x = 0; org_y = 0; org_z = 0;
    tall = 256; lower_len = 256; upper_len = 256;
    base_ang = 45; lower_ang = 0; upper_ang = -35;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].mode, dir_rows[i].dir, 1'b1, dir_rows[i].typed,
               dir_rows[i].pose);
    // Step the lower and upper joints back and forth with the largest steps.
    for (n = 0; n < 24; n++)
      send_cmd(n < 12 ? ajsk_pkg::MODE_LOWER : ajsk_pkg::MODE_UPPER,
               n[0] ? -4'sd8 : 4'sd7, 1'b1, 1'b0, '0);

    // Register settings: maxima (saturating), minima, odd height, zero lengths, then random.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_regs(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: load_regs(24'h800000, 24'h800000, 24'h800000, 16'h0000, 16'hFFFF, 16'hFFFF);
        2: load_regs(24'h000000, 24'h000000, 24'h000000, 16'h0001, 16'h0000, 16'h0000);
        3: load_regs(24'hFFFF00, 24'h001234, 24'hF00000, 16'h0301, 16'h0280, 16'h0400);
        default: load_regs(24'($urandom), 24'($urandom), 24'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (phase == 5) begin
        write_reg(3'd6, 24'h5A5A5A);   // unmapped index, must be ignored
        write_reg(3'd7, 24'hFFFFFF);
      end
      for (n = 0; n < (CmdCount - 44) / 6; n++) begin
        m = $urandom_range(0, 15) == 0 ? ajsk_pkg::MODE_HOME : 2'($urandom_range(0, 2));
        d = 4'($urandom);
        // hold-off until everything is back, once per phase
        if (n == 50) begin
          cmd_stop();
          while (pose_q.size() != 0) @(posedge clk);
        end
        if (phase == 5 && n > 150) calm = 1'b1;
        send_cmd(m, d, !calm, 1'b0, '0);
      end
    end

    drain();
    $display("covered %0d poses over six register settings incl. saturation,",
             poses_seen);
    $display("joint stops, odd base height and unmapped register writes");
    if (errors == 0) begin
      $display("arm_joint_step_and_kinematics_core_tb OK");
    end else begin
      $display("arm_joint_step_and_kinematics_core_tb NOT OK");
    end
    $finish;
  end

endmodule
